### src/mcsp_pkg.sv
// Shared constants, codes and types for the memory card sector protocol core.
// Depends on nothing; every other file refers to it by scoped names.
package mcsp_pkg;

    localparam int STORE_SECTORS = 1024;
    localparam int SECTOR_BYTES  = 128;
    localparam int STORE_SIZE    = STORE_SECTORS * SECTOR_BYTES;
    localparam int ADDR_W        = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
    localparam int BUF_AW        = $clog2(SECTOR_BYTES);
    localparam int CP_W          = BUF_AW + 1;

    // Input kinds carried on tuser
    localparam logic [1:0] KIND_BYTE     = 2'd0;
    localparam logic [1:0] KIND_DESELECT = 2'd1;
    localparam logic [1:0] KIND_LOAD     = 2'd2;

    // Command bytes
    localparam logic [7:0] CMD_NONE   = 8'h00;
    localparam logic [7:0] CMD_ACCESS = 8'h81;
    localparam logic [7:0] CMD_READ   = 8'h52;
    localparam logic [7:0] CMD_WRITE  = 8'h57;
    localparam logic [7:0] CMD_ID     = 8'h53;

    // Reply bytes
    localparam logic [7:0] RSP_ID1    = 8'h5A;
    localparam logic [7:0] RSP_ID2    = 8'h5D;
    localparam logic [7:0] RSP_CACK1  = 8'h5C;
    localparam logic [7:0] RSP_CACK2  = 8'h5D;
    localparam logic [7:0] RSP_GOOD   = 8'h47;
    localparam logic [7:0] RSP_BADSUM = 8'h4E;
    localparam logic [7:0] RSP_IDLE   = 8'hFF;
    localparam logic [7:0] RSP_ZERO   = 8'h00;

    localparam logic [7:0] DIR_UNREAD = 8'h08;
    localparam logic [7:0] DIR_CLEAN  = 8'h00;

    localparam logic [15:0] SECTOR_LIMIT = 16'd1023;

    // Byte positions within a read transaction
    localparam logic [7:0] RT_ID1    = 8'd0;
    localparam logic [7:0] RT_ID2    = 8'd1;
    localparam logic [7:0] RT_PAD    = 8'd2;
    localparam logic [7:0] RT_MSB    = 8'd3;
    localparam logic [7:0] RT_LSB    = 8'd4;
    localparam logic [7:0] RT_CACK2  = 8'd5;
    localparam logic [7:0] RT_EMSB   = 8'd6;
    localparam logic [7:0] RT_ELSB   = 8'd7;
    localparam logic [7:0] RT_DATA0  = 8'd8;
    localparam logic [7:0] RT_DATAN  = 8'd135;
    localparam logic [7:0] RT_CSUM   = 8'd136;
    localparam logic [7:0] RT_END    = 8'd137;

    // Byte positions within a write transaction
    localparam logic [7:0] WT_DATA0  = 8'd5;
    localparam logic [7:0] WT_DATAN  = 8'd132;
    localparam logic [7:0] WT_CSUM   = 8'd133;
    localparam logic [7:0] WT_CACK2  = 8'd134;
    localparam logic [7:0] WT_END    = 8'd135;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RDATA,
        ST_COMMIT
    } state_t;

endpackage

### src/memory_card_sector_protocol_core.sv
// Card side of the memory card byte exchange: command decoding, sector read,
// sector write with checksum, and commit into the sector store.
// Depends on mcsp_pkg for constants, codes and the state type.
//
// Usage
//   Input channel s_axis: one transfer per exchanged byte, deselect or store
//   load. tuser holds the kind, tdata holds byte_in and load_address.
//   Output channel m_axis: exactly one transfer per input transfer, in order,
//   with the reply byte in tdata and the acknowledge flag in tuser.
// Result path and commit
//   Most items have their result in the output register in the cycle after
//   the input transfer. A sector data byte of a read goes through the store's
//   registered read port and the ST_RDATA state first. The end byte of a good
//   write starts a copy of the 128-byte write buffer into the store: one entry
//   per cycle through the buffer read port, during which no input is taken; the
//   end byte's result is offered at once.
// Reset
//   rst_n clears the protocol state, sets the directory flag to 0x08 and
//   empties the output register. The store and write buffer are not cleared.
// Stalls
//   A result waits in the output register; the next input is taken while
//   it is being taken by the receiver, and held off while it stalls.
module memory_card_sector_protocol_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [7:0] byte_in, [24:8] load_address, [31:25] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] byte_out
    output logic [0:0]  m_axis_tuser    // [0] ack
);

    localparam int AW = mcsp_pkg::ADDR_W;
    localparam int BW = mcsp_pkg::BUF_AW;
    localparam int CW = mcsp_pkg::CP_W;

    // Input field unpacking
    logic [1:0]  kind;
    logic [7:0]  byte_in;
    logic [16:0] load_address;
    assign kind         = s_axis_tuser;
    assign byte_in      = s_axis_tdata[7:0];
    assign load_address = s_axis_tdata[24:8];

    // Protocol state
    mcsp_pkg::state_t state_reg, state_next;
    logic [7:0]  command_reg,   command_next;
    logic [7:0]  tick_reg,      tick_next;
    logic [15:0] sector_reg,    sector_next;
    logic [7:0]  csum_calc_reg, csum_calc_next;
    logic [7:0]  csum_recv_reg, csum_recv_next;
    logic        ack_flag_reg,  ack_flag_next;
    logic [7:0]  dir_flag_reg,  dir_flag_next;
    logic [CW-1:0] cp_reg,      cp_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg,  out_byte_next;
    logic        out_ack_reg,   out_ack_next;

    // Memories: sector store and write buffer, both with registered reads
    logic [7:0]  store_mem [mcsp_pkg::STORE_SIZE];
    logic [7:0]  buf_mem   [mcsp_pkg::SECTOR_BYTES];
    logic [7:0]  store_rdata_reg;
    logic [7:0]  buf_rdata_reg;

    logic          store_we, store_re;
    logic [AW-1:0] store_waddr, store_raddr;
    logic [7:0]    store_wdata;
    logic          buf_we, buf_re;
    logic [BW-1:0] buf_waddr, buf_raddr;

    logic          in_fire, out_fire;
    logic [7:0]    rd_off8, wr_off8;
    logic [CW-1:0] cp_prev;
    logic [31:0]   sector_base, rd_addr_full, cp_addr_full;
    logic          sector_in_store;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    // Take a new item only when idle and the output slot frees this cycle
    assign s_axis_tready = (state_reg == mcsp_pkg::ST_IDLE) && (!out_valid_reg || m_axis_tready);

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_byte_reg;
    assign m_axis_tuser[0] = out_ack_reg;

    // Address arithmetic: sector times 128 is a shift
    assign rd_off8         = tick_reg - mcsp_pkg::RT_DATA0;
    assign wr_off8         = tick_reg - mcsp_pkg::WT_DATA0;
    assign cp_prev         = cp_reg - CW'(1);
    assign sector_base     = 32'(sector_reg) * 32'(mcsp_pkg::SECTOR_BYTES);
    assign rd_addr_full    = sector_base + 32'(rd_off8[BW-1:0]);
    assign cp_addr_full    = sector_base + 32'(cp_prev[BW-1:0]);
    assign sector_in_store = 32'(sector_reg) < 32'(mcsp_pkg::STORE_SECTORS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mcsp_pkg::ST_IDLE;
            command_reg   <= mcsp_pkg::CMD_NONE;
            tick_reg      <= '0;
            sector_reg    <= '0;
            csum_calc_reg <= '0;
            csum_recv_reg <= '0;
            ack_flag_reg  <= 1'b1;
            dir_flag_reg  <= mcsp_pkg::DIR_UNREAD;
            cp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            command_reg   <= command_next;
            tick_reg      <= tick_next;
            sector_reg    <= sector_next;
            csum_calc_reg <= csum_calc_next;
            csum_recv_reg <= csum_recv_next;
            ack_flag_reg  <= ack_flag_next;
            dir_flag_reg  <= dir_flag_next;
            cp_reg        <= cp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload needs no reset
    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_ack_reg  <= out_ack_next;
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[store_waddr] <= store_wdata;
        end
        if (store_re)
        begin
            store_rdata_reg <= store_mem[store_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_mem[buf_waddr] <= byte_in;
        end
        if (buf_re)
        begin
            buf_rdata_reg <= buf_mem[buf_raddr];
        end
    end

    always_comb
    begin
        logic [7:0] eff_cmd;
        logic [7:0] r;
        logic       ack_out;
        logic       do_load;

        state_next     = state_reg;
        command_next   = command_reg;
        tick_next      = tick_reg;
        sector_next    = sector_reg;
        csum_calc_next = csum_calc_reg;
        csum_recv_next = csum_recv_reg;
        ack_flag_next  = ack_flag_reg;
        dir_flag_next  = dir_flag_reg;
        cp_next        = cp_reg;

        out_valid_next = out_valid_reg && !m_axis_tready;
        out_byte_next  = out_byte_reg;
        out_ack_next   = out_ack_reg;

        store_we    = 1'b0;
        store_re    = 1'b0;
        store_waddr = load_address[AW-1:0];
        store_wdata = byte_in;
        store_raddr = rd_addr_full[AW-1:0];
        buf_we      = 1'b0;
        buf_re      = 1'b0;
        buf_waddr   = wr_off8[BW-1:0];
        buf_raddr   = cp_reg[BW-1:0];

        eff_cmd = command_reg;
        r       = mcsp_pkg::RSP_IDLE;
        ack_out = 1'b0;
        do_load = 1'b0;

        case (state_reg)
            mcsp_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    do_load = 1'b1;
                    if (kind == mcsp_pkg::KIND_BYTE)
                    begin
                        if (command_reg == mcsp_pkg::CMD_NONE)
                        begin
                            // First byte: latch it and answer with the directory flag
                            command_next  = byte_in;
                            ack_flag_next = 1'b1;
                            r             = dir_flag_reg;
                        end
                        else
                        begin
                            if (command_reg == mcsp_pkg::CMD_ACCESS &&
                                (byte_in inside {mcsp_pkg::CMD_READ, mcsp_pkg::CMD_WRITE,
                                                 mcsp_pkg::CMD_ID}))
                            begin
                                eff_cmd      = byte_in;
                                command_next = byte_in;
                            end

                            if (eff_cmd == mcsp_pkg::CMD_READ)
                            begin
                                ack_flag_next = 1'b1;
                                tick_next     = tick_reg + 8'd1;
                                if (tick_reg == mcsp_pkg::RT_ID1)
                                begin
                                    r = mcsp_pkg::RSP_ID1;
                                end
                                else if (tick_reg == mcsp_pkg::RT_ID2)
                                begin
                                    r = mcsp_pkg::RSP_ID2;
                                end
                                else if (tick_reg == mcsp_pkg::RT_PAD)
                                begin
                                    r = mcsp_pkg::RSP_ZERO;
                                end
                                else if (tick_reg == mcsp_pkg::RT_MSB)
                                begin
                                    sector_next = {byte_in, 8'h00};
                                    r           = byte_in;
                                end
                                else if (tick_reg == mcsp_pkg::RT_LSB)
                                begin
                                    sector_next = sector_reg | {8'h00, byte_in};
                                    r           = mcsp_pkg::RSP_CACK1;
                                end
                                else if (tick_reg == mcsp_pkg::RT_CACK2)
                                begin
                                    r = mcsp_pkg::RSP_CACK2;
                                end
                                else if (tick_reg == mcsp_pkg::RT_EMSB)
                                begin
                                    r = sector_reg[15:8];
                                end
                                else if (tick_reg == mcsp_pkg::RT_ELSB)
                                begin
                                    r              = sector_reg[7:0];
                                    csum_calc_next = sector_reg[15:8] ^ sector_reg[7:0];
                                end
                                else if (tick_reg <= mcsp_pkg::RT_DATAN)
                                begin
                                    // Data byte: fetch from the store, finish next cycle
                                    store_re   = sector_in_store;
                                    tick_next  = tick_reg;
                                    do_load    = 1'b0;
                                    state_next = mcsp_pkg::ST_RDATA;
                                end
                                else if (tick_reg == mcsp_pkg::RT_CSUM)
                                begin
                                    r = csum_calc_reg;
                                end
                                else if (tick_reg == mcsp_pkg::RT_END)
                                begin
                                    r             = mcsp_pkg::RSP_GOOD;
                                    ack_flag_next = 1'b0;
                                end
                                else
                                begin
                                    command_next  = mcsp_pkg::CMD_NONE;
                                    tick_next     = '0;
                                    ack_flag_next = 1'b1;
                                    r             = mcsp_pkg::RSP_IDLE;
                                end
                            end
                            else if (eff_cmd == mcsp_pkg::CMD_WRITE)
                            begin
                                ack_flag_next = 1'b1;
                                tick_next     = tick_reg + 8'd1;
                                if (tick_reg == mcsp_pkg::RT_ID1)
                                begin
                                    r = mcsp_pkg::RSP_ID1;
                                end
                                else if (tick_reg == mcsp_pkg::RT_ID2)
                                begin
                                    r = mcsp_pkg::RSP_ID2;
                                end
                                else if (tick_reg == mcsp_pkg::RT_PAD)
                                begin
                                    r = mcsp_pkg::RSP_ZERO;
                                end
                                else if (tick_reg == mcsp_pkg::RT_MSB)
                                begin
                                    sector_next = {byte_in, 8'h00};
                                    r           = byte_in;
                                end
                                else if (tick_reg == mcsp_pkg::RT_LSB)
                                begin
                                    sector_next    = sector_reg | {8'h00, byte_in};
                                    csum_calc_next = sector_reg[15:8] ^ byte_in;
                                    r              = byte_in;
                                end
                                else if (tick_reg <= mcsp_pkg::WT_DATAN)
                                begin
                                    buf_we         = 1'b1;
                                    csum_calc_next = csum_calc_reg ^ byte_in;
                                    r              = byte_in;
                                end
                                else if (tick_reg == mcsp_pkg::WT_CSUM)
                                begin
                                    csum_recv_next = byte_in;
                                    r              = mcsp_pkg::RSP_CACK1;
                                end
                                else if (tick_reg == mcsp_pkg::WT_CACK2)
                                begin
                                    r = mcsp_pkg::RSP_CACK2;
                                end
                                else if (tick_reg == mcsp_pkg::WT_END)
                                begin
                                    if (sector_reg > mcsp_pkg::SECTOR_LIMIT)
                                    begin
                                        r = mcsp_pkg::RSP_IDLE;
                                    end
                                    else if (csum_recv_reg == csum_calc_reg)
                                    begin
                                        r             = mcsp_pkg::RSP_GOOD;
                                        dir_flag_next = mcsp_pkg::DIR_CLEAN;
                                        if (sector_in_store)
                                        begin
                                            // Copy the buffer into the store
                                            cp_next    = '0;
                                            state_next = mcsp_pkg::ST_COMMIT;
                                            if (sector_reg == 16'h0000)
                                            begin
                                                dir_flag_next = mcsp_pkg::DIR_UNREAD;
                                            end
                                        end
                                    end
                                    else
                                    begin
                                        r = mcsp_pkg::RSP_BADSUM;
                                    end
                                    command_next  = mcsp_pkg::CMD_NONE;
                                    tick_next     = '0;
                                    ack_flag_next = 1'b0;
                                end
                                else
                                begin
                                    command_next  = mcsp_pkg::CMD_NONE;
                                    tick_next     = '0;
                                    ack_flag_next = 1'b1;
                                    r             = mcsp_pkg::RSP_IDLE;
                                end
                            end
                            else
                            begin
                                // Unknown command or get-ID: drop back to idle
                                command_next  = mcsp_pkg::CMD_NONE;
                                tick_next     = '0;
                                ack_flag_next = 1'b1;
                                r             = mcsp_pkg::RSP_IDLE;
                            end
                        end
                        ack_out = ack_flag_next;
                    end
                    else
                    begin
                        if (kind == mcsp_pkg::KIND_DESELECT)
                        begin
                            command_next  = mcsp_pkg::CMD_NONE;
                            tick_next     = '0;
                            ack_flag_next = 1'b1;
                        end
                        else if (kind == mcsp_pkg::KIND_LOAD)
                        begin
                            store_we = 32'(load_address) < 32'(mcsp_pkg::STORE_SIZE);
                        end
                        r       = mcsp_pkg::RSP_IDLE;
                        ack_out = 1'b0;
                    end
                end
            end

            mcsp_pkg::ST_RDATA:
            begin
                // Store data is out of the read port now; out-of-range sectors read 0xFF
                r              = sector_in_store ? store_rdata_reg : mcsp_pkg::RSP_IDLE;
                csum_calc_next = csum_calc_reg ^ r;
                tick_next      = tick_reg + 8'd1;
                ack_flag_next  = 1'b1;
                ack_out        = 1'b1;
                do_load        = 1'b1;
                state_next     = mcsp_pkg::ST_IDLE;
            end

            mcsp_pkg::ST_COMMIT:
            begin
                // Read buffer entry cp, write entry cp-1 fetched last cycle
                buf_re      = cp_reg < CW'(mcsp_pkg::SECTOR_BYTES);
                store_we    = cp_reg != '0;
                store_waddr = cp_addr_full[AW-1:0];
                store_wdata = buf_rdata_reg;
                cp_next     = cp_reg + CW'(1);
                if (cp_reg == CW'(mcsp_pkg::SECTOR_BYTES))
                begin
                    state_next = mcsp_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = mcsp_pkg::ST_IDLE;
            end
        endcase

        if (do_load)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = r;
            out_ack_next   = ack_out;
        end
    end

endmodule

### src/mcsp_checker.sv
// Port-level checks for memory_card_sector_protocol_core, bound to the top level.
// Depends on the top level's port list and on mcsp_pkg for the kind and reply codes.
module mcsp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // Hold a stalled result until it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // No input is taken while a result waits without being taken
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready && m_axis_tvalid |-> m_axis_tready)
        else $error("input ready while output stalled");

    // Any non-byte transfer, such as a deselect or load, answers 0xFF without acknowledge next cycle
    a_nonbyte_reply: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser != mcsp_pkg::KIND_BYTE |=>
            m_axis_tvalid && m_axis_tdata == mcsp_pkg::RSP_IDLE && !m_axis_tuser[0])
        else $error("bad reply to non-byte transfer");

endmodule

bind memory_card_sector_protocol_core mcsp_checker u_mcsp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### dv/tb_memory_card_sector_protocol_core.sv
`timescale 1ns / 100ps
// Testbench for memory_card_sector_protocol_core: drives command, sector read and
// sector write byte streams and checks every reply against a built-in card model.
// Depends on mcsp_pkg and the core RTL only.
module tb_memory_card_sector_protocol_core;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 200;   // covers a full commit copy after the last reply
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 200;
    localparam int NOISE_ITEMS  = 40;
    // Frames are indexed by tick; position 0 is the read or write command byte itself
    localparam int WRITE_FRAME  = 136;
    localparam int READ_FRAME   = 138;

    // tuser code the core must treat as a no-op
    localparam logic [1:0] KIND_SPARE = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic       ack;
    } reply_t;

    logic        clk;
    logic        rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_data;    // [7:0] byte_in, [24:8] load_address, [31:25] zero
    logic [1:0]  s_user;    // [1:0] kind
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_data;    // [7:0] byte_out
    logic [0:0]  m_user;    // [0] ack

    memory_card_sector_protocol_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user)
    );

    // Card model state
    logic [7:0]  card_cmd;
    logic [7:0]  card_tick;
    logic [15:0] card_sector;
    logic [7:0]  card_sum;
    logic [7:0]  card_sum_rx;
    logic        card_ack;
    logic [7:0]  card_dir;
    logic [7:0]  card_wbuf [mcsp_pkg::SECTOR_BYTES];
    logic [7:0]  card_store [mcsp_pkg::STORE_SIZE];

    // Sectors whose every byte has been loaded or committed; only these, or sectors past the store, get read
    int filled_sectors [$];

    reply_t pending_replies [$];

    int src_idle_pct;
    int sink_stall_pct;
    int hold_request;
    int hold_left;
    int errors;
    int replies_checked;
    int items_sent;
    int commits_done;
    int reads_done;
    int cycle_count;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Card model
    // ------------------------------------------------------------------
    function automatic void card_go_idle();
        card_cmd  = mcsp_pkg::CMD_NONE;
        card_tick = '0;
        card_ack  = 1'b1;
    endfunction

    function automatic logic [7:0] read_frame_byte(logic [7:0] b);
        logic [7:0] r;
        card_ack = 1'b1;
        if (card_tick == mcsp_pkg::RT_ID1)
            r = mcsp_pkg::RSP_ID1;
        else if (card_tick == mcsp_pkg::RT_ID2)
            r = mcsp_pkg::RSP_ID2;
        else if (card_tick == mcsp_pkg::RT_PAD)
            r = mcsp_pkg::RSP_ZERO;
        else if (card_tick == mcsp_pkg::RT_MSB)
        begin
            card_sector = {b, 8'h00};
            r = b;
        end
        else if (card_tick == mcsp_pkg::RT_LSB)
        begin
            card_sector[7:0] = b;
            r = mcsp_pkg::RSP_CACK1;
        end
        else if (card_tick == mcsp_pkg::RT_CACK2)
            r = mcsp_pkg::RSP_CACK2;
        else if (card_tick == mcsp_pkg::RT_EMSB)
            r = card_sector[15:8];
        else if (card_tick == mcsp_pkg::RT_ELSB)
        begin
            r = card_sector[7:0];
            card_sum = card_sector[15:8] ^ card_sector[7:0];
        end
        else if (card_tick <= mcsp_pkg::RT_DATAN)
        begin
            // sectors past the store read as all ones and still enter the checksum
            if (card_sector >= mcsp_pkg::STORE_SECTORS)
                r = mcsp_pkg::RSP_IDLE;
            else
                r = card_store[card_sector * mcsp_pkg::SECTOR_BYTES
                               + (card_tick - mcsp_pkg::RT_DATA0)];
            card_sum ^= r;
        end
        else if (card_tick == mcsp_pkg::RT_CSUM)
            r = card_sum;
        else if (card_tick == mcsp_pkg::RT_END)
        begin
            r = mcsp_pkg::RSP_GOOD;
            card_ack = 1'b0;
            reads_done++;
        end
        else
        begin
            // byte after the end byte: drop back to idle
            card_go_idle();
            return mcsp_pkg::RSP_IDLE;
        end
        card_tick++;
        return r;
    endfunction

    function automatic logic [7:0] write_frame_byte(logic [7:0] b);
        logic [7:0] r;
        int i;
        card_ack = 1'b1;
        if (card_tick == mcsp_pkg::RT_ID1)
            r = mcsp_pkg::RSP_ID1;
        else if (card_tick == mcsp_pkg::RT_ID2)
            r = mcsp_pkg::RSP_ID2;
        else if (card_tick == mcsp_pkg::RT_PAD)
            r = mcsp_pkg::RSP_ZERO;
        else if (card_tick == mcsp_pkg::RT_MSB)
        begin
            card_sector = {b, 8'h00};
            r = b;
        end
        else if (card_tick == mcsp_pkg::RT_LSB)
        begin
            card_sector[7:0] = b;
            card_sum = card_sector[15:8] ^ card_sector[7:0];
            r = b;
        end
        else if (card_tick <= mcsp_pkg::WT_DATAN)
        begin
            card_wbuf[card_tick - mcsp_pkg::WT_DATA0] = b;
            card_sum ^= b;
            r = b;
        end
        else if (card_tick == mcsp_pkg::WT_CSUM)
        begin
            card_sum_rx = b;
            r = mcsp_pkg::RSP_CACK1;
        end
        else if (card_tick == mcsp_pkg::WT_CACK2)
            r = mcsp_pkg::RSP_CACK2;
        else if (card_tick == mcsp_pkg::WT_END)
        begin
            if (card_sector > mcsp_pkg::SECTOR_LIMIT)
                r = mcsp_pkg::RSP_IDLE;
            else if (card_sum_rx == card_sum)
            begin
                // good write: commit the buffer, sector zero marks the directory unread
                r = mcsp_pkg::RSP_GOOD;
                card_dir = mcsp_pkg::DIR_CLEAN;
                for (i = 0; i < mcsp_pkg::SECTOR_BYTES; i++)
                    card_store[card_sector * mcsp_pkg::SECTOR_BYTES + i] = card_wbuf[i];
                if (card_sector == '0)
                    card_dir = mcsp_pkg::DIR_UNREAD;
                filled_sectors.push_back(card_sector);
                commits_done++;
            end
            else
                r = mcsp_pkg::RSP_BADSUM;
            card_go_idle();
            card_ack = 1'b0;
            return r;
        end
        else
        begin
            card_go_idle();
            return mcsp_pkg::RSP_IDLE;
        end
        card_tick++;
        return r;
    endfunction

    function automatic logic [7:0] card_exchange(logic [7:0] b);
        logic [7:0] cur;
        cur = card_cmd;
        if (cur == mcsp_pkg::CMD_NONE)
        begin
            // first byte of a transaction: latch it, answer the directory flag
            card_cmd = b;
            card_ack = 1'b1;
            return card_dir;
        end
        if (cur == mcsp_pkg::CMD_ACCESS)
        begin
            if (b == mcsp_pkg::CMD_READ || b == mcsp_pkg::CMD_WRITE
                || b == mcsp_pkg::CMD_ID)
            begin
                card_cmd = b;
                cur = b;
            end
            else
            begin
                card_go_idle();
                return mcsp_pkg::RSP_IDLE;
            end
        end
        if (cur == mcsp_pkg::CMD_READ)
            return read_frame_byte(b);
        if (cur == mcsp_pkg::CMD_WRITE)
            return write_frame_byte(b);
        card_go_idle();
        return mcsp_pkg::RSP_IDLE;
    endfunction

    function automatic reply_t card_answer(logic [1:0] kind, logic [7:0] b,
                                           logic [16:0] addr);
        reply_t rep;
        rep.data = mcsp_pkg::RSP_IDLE;
        rep.ack  = 1'b0;
        case (kind)
            mcsp_pkg::KIND_BYTE:
            begin
                rep.data = card_exchange(b);
                rep.ack  = card_ack;
            end
            mcsp_pkg::KIND_DESELECT: card_go_idle();
            mcsp_pkg::KIND_LOAD: if (addr < mcsp_pkg::STORE_SIZE) card_store[addr] = b;
            default: ;
        endcase
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Offer one transfer; predict its reply once the core takes it.
    task automatic send_item(logic [1:0] kind, logic [7:0] b, logic [16:0] addr);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_valid <= 1'b0;
            @(negedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= kind;
        s_data  <= {7'd0, addr, b};
        do
            @(posedge clk);
        while (!s_ready);
        pending_replies.push_back(card_answer(kind, b, addr));
        items_sent++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_item(mcsp_pkg::KIND_BYTE, b, 17'($urandom_range(mcsp_pkg::STORE_SIZE - 1)));
    endtask

    task automatic send_deselect();
        send_item(mcsp_pkg::KIND_DESELECT, 8'($urandom_range(255)),
                  17'($urandom_range(mcsp_pkg::STORE_SIZE - 1)));
    endtask

    // Drop valid and hold off until every predicted reply has been checked.
    task automatic wait_results();
        @(negedge clk);
        s_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_idling(int src_pct, int sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    // Frames start from idle so the sector bytes land on the right positions.
    task automatic ensure_idle();
        if (card_cmd != mcsp_pkg::CMD_NONE)
            send_deselect();
    endtask

    // Sector write; stop below WRITE_FRAME truncates it with a deselect.
    task automatic do_write(logic [15:0] sector, bit good_sum, int stop);
        logic [7:0] frame [WRITE_FRAME];
        logic [7:0] sum;
        int i;
        for (i = 0; i < WRITE_FRAME; i++)
            frame[i] = 8'($urandom_range(255));
        frame[mcsp_pkg::RT_MSB] = sector[15:8];
        frame[mcsp_pkg::RT_LSB] = sector[7:0];
        sum = sector[15:8] ^ sector[7:0];
        for (i = mcsp_pkg::WT_DATA0; i <= mcsp_pkg::WT_DATAN; i++)
            sum ^= frame[i];
        frame[mcsp_pkg::WT_CSUM] = good_sum ? sum : sum ^ 8'($urandom_range(255, 1));
        ensure_idle();
        send_byte(mcsp_pkg::CMD_ACCESS);
        send_byte(mcsp_pkg::CMD_WRITE);
        for (i = 1; i < stop; i++)
            send_byte(frame[i]);
        if (stop < WRITE_FRAME)
            send_deselect();
    endtask

    // Sector read; only filled sectors or sectors past the store are asked for.
    task automatic do_read(logic [15:0] sector, bit extra, int stop);
        logic [7:0] frame [READ_FRAME];
        int i;
        for (i = 0; i < READ_FRAME; i++)
            frame[i] = 8'($urandom_range(255));
        frame[mcsp_pkg::RT_MSB] = sector[15:8];
        frame[mcsp_pkg::RT_LSB] = sector[7:0];
        ensure_idle();
        send_byte(mcsp_pkg::CMD_ACCESS);
        send_byte(mcsp_pkg::CMD_READ);
        for (i = 1; i < stop; i++)
            send_byte(frame[i]);
        if (stop < READ_FRAME)
            send_deselect();
        else if (extra)
            send_byte(8'($urandom_range(255)));
    endtask

    // Mostly protocol codes and random bytes, with deselects, loads and spare kinds.
    task automatic noise_burst(int n);
        logic [7:0] b;
        int i;
        for (i = 0; i < n; i++)
        begin
            case ($urandom_range(9))
                7: send_deselect();
                8: send_item(mcsp_pkg::KIND_LOAD, 8'($urandom_range(255)),
                             17'($urandom_range(mcsp_pkg::STORE_SIZE - 1)));
                9: send_item(KIND_SPARE, 8'($urandom_range(255)),
                             17'($urandom_range(mcsp_pkg::STORE_SIZE - 1)));
                default:
                begin
                    if ($urandom_range(2) == 0)
                    begin
                        case ($urandom_range(4))
                            0: b = mcsp_pkg::CMD_ACCESS;
                            1: b = mcsp_pkg::CMD_READ;
                            2: b = mcsp_pkg::CMD_WRITE;
                            3: b = mcsp_pkg::CMD_ID;
                            default: b = mcsp_pkg::CMD_NONE;
                        endcase
                    end
                    else
                        b = 8'($urandom_range(255));
                    // steer any accidental read past the store, never onto unknown data
                    if (card_cmd == mcsp_pkg::CMD_READ && card_tick == mcsp_pkg::RT_MSB
                        && b < (mcsp_pkg::STORE_SECTORS >> 8))
                        b = 8'($urandom_range(255, mcsp_pkg::STORE_SECTORS >> 8));
                    send_byte(b);
                end
            endcase
        end
    endtask

    task automatic random_transaction();
        logic [15:0] sector;
        int r;
        r = $urandom_range(9);
        if (r < 4)
        begin
            case ($urandom_range(9))
                0, 1:       sector = '0;
                2, 3, 4, 5: sector = 16'($urandom_range(15, 1));
                6:          sector = 16'(mcsp_pkg::STORE_SECTORS - 1);
                7, 8:       sector = 16'($urandom_range(65535, mcsp_pkg::STORE_SECTORS));
                default:    sector = 16'($urandom_range(mcsp_pkg::STORE_SECTORS - 1, 16));
            endcase
            do_write(sector, $urandom_range(9) < 8,
                     ($urandom_range(9) == 0) ? $urandom_range(WRITE_FRAME - 1)
                                              : WRITE_FRAME);
        end
        else if (r < 8)
        begin
            if (filled_sectors.size() != 0 && $urandom_range(9) < 7)
                sector = 16'(filled_sectors[$urandom_range(filled_sectors.size() - 1)]);
            else
                sector = 16'($urandom_range(65535, mcsp_pkg::STORE_SECTORS));
            do_read(sector, $urandom_range(1),
                    ($urandom_range(9) == 0) ? $urandom_range(READ_FRAME - 1)
                                             : READ_FRAME);
        end
        else
            noise_burst($urandom_range(20, 5));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Command decoding, spare kinds, truncated frames and store loads at the edges.
    task automatic test_command_decode();
        set_idling(0, 0);
        send_byte(mcsp_pkg::CMD_NONE);       // no command: directory flag, stay idle
        send_byte(8'hFF);                    // unknown command, then its 0xFF reply
        send_byte(mcsp_pkg::CMD_NONE);
        send_item(KIND_SPARE, 8'hFF, 17'h1FFFF);
        send_byte(mcsp_pkg::CMD_ACCESS);     // get-ID through the access prefix
        send_byte(mcsp_pkg::CMD_ID);
        send_byte(mcsp_pkg::CMD_ID);         // get-ID as first byte
        send_byte(8'hAA);
        send_byte(mcsp_pkg::CMD_ACCESS);     // access followed by a bad byte
        send_byte(mcsp_pkg::CMD_NONE);
        send_byte(mcsp_pkg::CMD_ACCESS);     // write cut short by a deselect
        send_byte(mcsp_pkg::CMD_WRITE);
        send_byte(8'h12);
        send_deselect();
        send_byte(mcsp_pkg::CMD_READ);       // read entered without the prefix
        send_byte(8'h00);
        send_byte(8'hFF);
        send_deselect();
        send_item(mcsp_pkg::KIND_LOAD, 8'h00, 17'h1FFFF);
        send_item(mcsp_pkg::KIND_LOAD, 8'hFF, 17'h00000);
        send_byte(mcsp_pkg::CMD_ACCESS);     // spare kind in mid-frame changes nothing
        send_item(KIND_SPARE, 8'h00, 17'h00000);
        send_byte(mcsp_pkg::CMD_READ);
        send_deselect();
        wait_results();
    endtask

    // Fill the last sector of the store through the back door.
    task automatic test_store_load();
        int i;
        set_idling(19, 19);
        for (i = 0; i < mcsp_pkg::SECTOR_BYTES; i++)
            send_item(mcsp_pkg::KIND_LOAD, 8'($urandom_range(255)),
                      17'((mcsp_pkg::STORE_SECTORS - 1) * mcsp_pkg::SECTOR_BYTES + i));
        filled_sectors.push_back(mcsp_pkg::STORE_SECTORS - 1);
        wait_results();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering.
    task automatic test_backpressure();
        set_idling(0, 0);
        hold_request = HOLD_CYCLES;
        noise_burst(NOISE_ITEMS);
        wait_results();
    endtask

    // Full frames and random traffic under each idling pattern.
    task automatic test_traffic();
        int ph;
        int phase_start;
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: set_idling(0, 0);
                1: set_idling(68, 0);
                2: set_idling(0, 68);
                default: set_idling(19, 19);
            endcase
            phase_start = items_sent;
            case (ph)
                0: do_write(16'h0000, 1'b1, WRITE_FRAME);    // directory back to unread
                1: do_read(16'h0000, 1'b1, READ_FRAME);      // end byte then idle byte
                2: do_read(16'(mcsp_pkg::STORE_SECTORS - 1), 1'b0, READ_FRAME);
                default:
                begin
                    do_write(16'h0006, 1'b0, WRITE_FRAME);   // bad checksum
                    while (items_sent - phase_start < PHASE_ITEMS)
                        random_transaction();
                end
            endcase
            wait_results();
        end
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------
    // Drive tready at the falling edge; a hold-off request overrides random stalls.
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_ready <= 1'b0;
        end
        else
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Compare each reply transfer with the oldest prediction.
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && m_valid && m_ready)
        begin
            if (pending_replies.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected reply byte %02h ack %0b", $time, m_data, m_user);
            end
            else
            begin
                want = pending_replies.pop_front();
                replies_checked++;
                if (m_data !== want.data)
                begin
                    errors++;
                    $display("%0t: reply byte expected %02h actual %02h",
                             $time, want.data, m_data);
                end
                if (m_user[0] !== want.ack)
                begin
                    errors++;
                    $display("%0t: ack expected %0b actual %0b", $time, want.ack, m_user[0]);
                end
            end
        end
    end

    // Hard stop if the run hangs.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        s_valid         = 1'b0;
        s_data          = '0;
        s_user          = mcsp_pkg::KIND_BYTE;
        m_ready         = 1'b0;
        src_idle_pct    = 0;
        sink_stall_pct  = 0;
        hold_request    = 0;
        hold_left       = 0;
        errors          = 0;
        replies_checked = 0;
        items_sent      = 0;
        commits_done    = 0;
        reads_done      = 0;
        card_cmd        = mcsp_pkg::CMD_NONE;
        card_tick       = '0;
        card_sector     = '0;
        card_sum        = '0;
        card_sum_rx     = '0;
        card_ack        = 1'b1;
        card_dir        = mcsp_pkg::DIR_UNREAD;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_command_decode();
        test_store_load();
        test_backpressure();
        test_traffic();

        // Let a trailing commit copy finish and catch any stray reply.
        wait_results();
        set_idling(0, 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_replies.size() != 0)
        begin
            errors++;
            $display("%0t: %0d replies never arrived", $time, pending_replies.size());
        end

        $display("Sent %0d transfers, checked %0d replies.", items_sent, replies_checked);
        $display("Frames: %0d sector commits, %0d complete sector reads.",
                 commits_done, reads_done);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### filelist.f
src/mcsp_pkg.sv
src/memory_card_sector_protocol_core.sv
src/mcsp_checker.sv
dv/tb_memory_card_sector_protocol_core.sv
